// File: src/tseq_pkg.sv
// shared types and constants for the timer slot expiry queue
package tseq_pkg;

  localparam int unsigned SLOTS_DEF = 16;
  localparam logic [15:0] IDLE_WAIT_RST = 16'd1000;
  localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

  localparam logic [1:0] REQ_ADD = 2'd0;
  localparam logic [1:0] REQ_CANCEL = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  localparam logic [1:0] RESP_ADD = 2'd0;
  localparam logic [1:0] RESP_CANCEL = 2'd1;
  localparam logic [1:0] RESP_FIRED = 2'd2;
  localparam logic [1:0] RESP_DONE = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [47:0] now_ms;
    logic [47:0] deadline_ms;
    logic [31:0] period_ms;
    logic        one_shot;
    logic [3:0]  cancel_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  resp_kind;
    logic [3:0]  slot_id;
    logic        ok;
    logic [47:0] wait_ms;
    logic        last;
  } resp_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture request
    logic do_add;    // allocate and write slot
    logic do_cancel; // cancel slot
    logic scan_clr;  // start a scan pass
    logic scan_step; // examine one slot
    logic fire;      // fire the picked slot
    logic emit;      // load output register from result mux
    logic [1:0] kind;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       scan_end; // last slot of the pass examined
    logic       pick_vld; // an expired slot was found this pass
  } sts_t;

endpackage

// File: src/tseq_datapath.sv
// slot tables, free list and scan unit of the timer queue
module tseq_datapath #(
  parameter int unsigned SLOTS = tseq_pkg::SLOTS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tseq_pkg::req_t req_i,
  input  logic [15:0]    idle_wait_i,
  input  tseq_pkg::ctl_t ctl_i,
  output tseq_pkg::sts_t sts_o,
  output tseq_pkg::resp_t resp_o
);
  import tseq_pkg::*;

  localparam int unsigned IW = $clog2(SLOTS);
  localparam int unsigned CW = $clog2(SLOTS + 1);

  req_t              req_q;
  logic [SLOTS-1:0]  active_q, fired_q;
  logic [SLOTS-1:0]  once_q;
  logic [31:0]       period_q [SLOTS];
  logic [47:0]       due_q [SLOTS];
  logic [IW-1:0]     free_q [SLOTS];
  logic [CW-1:0]     free_cnt_q, used_q;
  logic [IW-1:0]     idx_q;
  logic              pick_vld_q, any_q;
  logic [IW-1:0]     pick_q;
  logic [47:0]       pick_due_q, best_q;
  logic [IW-1:0]     res_id_q;
  logic              res_ok_q;
  resp_t             resp_q;

  // add allocation
  logic              can_add, from_free;
  logic [IW-1:0]     new_id;
  logic [CW-1:0]     free_top;
  assign from_free = (free_cnt_q != '0);
  assign free_top  = free_cnt_q - CW'(1);
  assign can_add   = from_free || (used_q < CW'(SLOTS));
  assign new_id    = from_free ? free_q[free_top[IW-1:0]] : used_q[IW-1:0];

  // cancel check: id must have been handed out before
  logic [IW-1:0] cid;
  logic          cid_ok;
  assign cid    = IW'(req_q.cancel_id);
  assign cid_ok = (32'(req_q.cancel_id) < 32'(used_q));

  // scan element
  logic [47:0] cur_due;
  logic        cur_exp;
  assign cur_due = due_q[idx_q];
  assign cur_exp = active_q[idx_q] && !fired_q[idx_q] && (cur_due <= req_q.now_ms);

  // reschedule sum
  logic [48:0] nd;
  assign nd = {1'b0, req_q.now_ms} + {17'd0, period_q[pick_q]};

  logic push_ok;
  assign push_ok = free_cnt_q < CW'(SLOTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= '0;
      fired_q    <= '0;
      free_cnt_q <= '0;
      used_q     <= '0;
      idx_q      <= '0;
      pick_vld_q <= 1'b0;
      any_q      <= 1'b0;
    end else begin
      if (ctl_i.load) fired_q <= '0;
      if (ctl_i.do_add && can_add) begin
        active_q[new_id] <= 1'b1;
        if (from_free) free_cnt_q <= free_top;
        else used_q <= used_q + CW'(1);
      end
      if (ctl_i.do_cancel && cid_ok && active_q[cid]) begin
        active_q[cid] <= 1'b0;
        if (push_ok) free_cnt_q <= free_cnt_q + CW'(1);
      end
      if (ctl_i.scan_clr) begin
        idx_q      <= '0;
        pick_vld_q <= 1'b0;
        any_q      <= 1'b0;
      end else if (ctl_i.scan_step) begin
        idx_q <= (idx_q == IW'(SLOTS - 1)) ? '0 : idx_q + IW'(1);
        if (cur_exp && (!pick_vld_q || cur_due < pick_due_q)) pick_vld_q <= 1'b1;
        if (active_q[idx_q] && (!any_q || cur_due < best_q)) any_q <= 1'b1;
      end
      if (ctl_i.fire) begin
        fired_q[pick_q] <= 1'b1;
        if (once_q[pick_q]) begin
          active_q[pick_q] <= 1'b0;
          if (push_ok) free_cnt_q <= free_cnt_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) req_q <= req_i;
    if (ctl_i.do_add) begin
      res_id_q <= can_add ? new_id : '0;
      res_ok_q <= can_add;
      if (can_add) begin
        once_q[new_id]   <= req_q.one_shot;
        period_q[new_id] <= req_q.period_ms;
        due_q[new_id]    <= req_q.deadline_ms;
      end
    end
    if (ctl_i.do_cancel) begin
      res_id_q <= cid;
      res_ok_q <= cid_ok;
      if (cid_ok && active_q[cid] && push_ok) free_q[free_cnt_q[IW-1:0]] <= cid;
    end
    if (ctl_i.scan_step) begin
      if (cur_exp && (!pick_vld_q || cur_due < pick_due_q)) begin
        pick_q     <= idx_q;
        pick_due_q <= cur_due;
      end
      if (active_q[idx_q] && (!any_q || cur_due < best_q)) best_q <= cur_due;
    end
    if (ctl_i.fire) begin
      res_id_q <= pick_q;
      res_ok_q <= 1'b1;
      if (once_q[pick_q]) begin
        if (push_ok) free_q[free_cnt_q[IW-1:0]] <= pick_q;
      end else begin
        due_q[pick_q] <= nd[48] ? MAX48 : nd[47:0];
      end
    end
    if (ctl_i.emit) begin
      resp_q.resp_kind <= ctl_i.kind;
      resp_q.last      <= (ctl_i.kind != RESP_FIRED);
      if (ctl_i.kind == RESP_DONE) begin
        resp_q.slot_id <= '0;
        resp_q.ok      <= 1'b1;
        resp_q.wait_ms <= !any_q ? {32'd0, idle_wait_i}
                        : (best_q > req_q.now_ms ? best_q - req_q.now_ms : '0);
      end else begin
        resp_q.slot_id <= 4'(res_id_q);
        resp_q.ok      <= res_ok_q;
        resp_q.wait_ms <= '0;
      end
    end
  end

  assign sts_o.req_type = req_q.req_type;
  assign sts_o.scan_end = (idx_q == IW'(SLOTS - 1));
  assign sts_o.pick_vld = pick_vld_q;
  assign resp_o = resp_q;
endmodule

// File: src/tseq_ctrl.sv
// request sequencer of the timer queue
module tseq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  output logic           resp_valid_o,
  input  logic           resp_ready_i,
  input  tseq_pkg::sts_t sts_i,
  output tseq_pkg::ctl_t ctl_o
);
  import tseq_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_FIRE = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       vld_q, vld_d;
  logic [1:0] kind_q, kind_d;

  logic out_free;
  assign out_free = !vld_q || resp_ready_i;

  always_comb begin
    state_d = state_q;
    vld_d   = vld_q && !resp_ready_i;
    kind_d  = kind_q;
    ctl_o   = '0;
    ctl_o.kind = kind_q;
    req_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          ctl_o.load = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts_i.req_type)
          REQ_ADD: begin
            ctl_o.do_add = 1'b1; kind_d = RESP_ADD; state_d = S_OUT;
          end
          REQ_CANCEL: begin
            ctl_o.do_cancel = 1'b1; kind_d = RESP_CANCEL; state_d = S_OUT;
          end
          REQ_TICK: begin
            ctl_o.scan_clr = 1'b1; state_d = S_SCAN;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SCAN: begin
        ctl_o.scan_step = 1'b1;
        if (sts_i.scan_end) state_d = S_FIRE;
      end
      S_FIRE: begin
        if (sts_i.pick_vld) begin
          ctl_o.fire = 1'b1; kind_d = RESP_FIRED; state_d = S_OUT;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        kind_d = RESP_DONE; state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          ctl_o.emit = 1'b1;
          vld_d = 1'b1;
          if (kind_q == RESP_FIRED) begin
            ctl_o.scan_clr = 1'b1; state_d = S_SCAN;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vld_q   <= 1'b0;
      kind_q  <= RESP_ADD;
    end else begin
      state_q <= state_d;
      vld_q   <= vld_d;
      kind_q  <= kind_d;
    end
  end

  assign resp_valid_o = vld_q;
endmodule

// File: src/timer_slot_expiry_queue.sv
// top level of the timer slot expiry queue
// add or cancel: request registered, decoded, then its result word emitted once the output is free
// tick: one scan pass per fired slot and one final pass, each fired slot emitting a fired word,
//   then the done word; the scan examines a single slot per step; new requests are taken in idle only
// the result word sits in an output register, so the next step runs while it waits
// reset clears slot active bits, free list count, used count and sets idle wait to 1000
module timer_slot_expiry_queue #(
  parameter int unsigned SLOTS = tseq_pkg::SLOTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  tseq_pkg::req_t   req_i,
  output logic             resp_valid_o,
  input  logic             resp_ready_i,
  output tseq_pkg::resp_t  resp_o,
  input  logic             cfg_we_i,
  input  logic [15:0]      cfg_wdata_i
);
  import tseq_pkg::*;

  // idle wait register, to be written only while the queue is quiet; the block does not enforce this
  logic [15:0] idle_wait_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idle_wait_q <= IDLE_WAIT_RST;
    else if (cfg_we_i) idle_wait_q <= cfg_wdata_i;
  end

  // command and status between sequencer and datapath
  ctl_t ctl;
  sts_t sts;

  tseq_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .req_valid_i, .req_ready_o,
    .resp_valid_o, .resp_ready_i,
    .sts_i(sts), .ctl_o(ctl)
  );

  // slot tables, free list stack and sequential min scan
  tseq_datapath #(.SLOTS(SLOTS)) u_dp (
    .clk_i, .rst_ni,
    .req_i, .idle_wait_i(idle_wait_q),
    .ctl_i(ctl), .sts_o(sts), .resp_o
  );
endmodule
